// File: hdl/tds_pkg.sv
// Shared types and constants for the tridiagonal system solver.
package tds_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned IdxW = 6;
	localparam int unsigned QuoW = 49;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DEN,
		ST_DIV_C,
		ST_WAIT_C,
		ST_DIV_D,
		ST_WAIT_D,
		ST_WRITE_D,
		ST_BS_RD,
		ST_BS_MUL,
		ST_BS_OUT,
		ST_BS_WAIT
	} tds_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic form_den;
		logic start_div_c;
		logic start_div_d;
		logic write_c;
		logic write_d;
		logic bs_read;
		logic bs_mul;
		logic bs_form;
		logic bs_first;
	} tds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} tds_stat_t;

	// Saturate a 48 bit signed value to 32 bits.
	function automatic logic signed [WordW-1:0] sat48(input logic signed [47:0] v);
		logic signed [WordW-1:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[WordW-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/tridiagonal_system_solver.sv
// Top level of the tridiagonal system solver (Thomas algorithm, Q16.16).
//
//  channel | signals                                           | direction
//  input   | in_valid, in_ready, sub/diag/super_coef, rhs, last | in
//  output  | out_valid, out_ready, solution_*, final, error     | out
//
// A row occupies the solver through its capture, load, product and denominator
// states and two serial 49 step divisions in the shared divider. A last row
// skips the first division before back substitution. A zero divisor finishes
// its division in the cycle after its start. Each solution word then passes
// through the store read and the multiplier. Reset is asynchronous and the
// stores need none. Stalls on the output hold the current word, and no row is
// taken until all words are out.
module tridiagonal_system_solver
	import tds_pkg::*;
#(
	parameter int MAX_ROWS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [WordW-1:0] sub_coef,
	input  logic signed [WordW-1:0] diag_coef,
	input  logic signed [WordW-1:0] super_coef,
	input  logic signed [WordW-1:0] rhs_value,
	input  logic                    last_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WordW-1:0] solution_value,
	output logic [IdxW-1:0]         solution_index,
	output logic                    final_out,
	output logic                    pivot_error
);

	tds_cmd_t        cmd;
	tds_stat_t       stat;
	logic            den_zero;
	logic [IdxW-1:0] row_idx;
	logic            first_row;

	tds_ctrl #(.MaxRows(MAX_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.last_row(last_row), .out_ready(out_ready), .out_valid(out_valid),
		.stat(stat), .den_zero(den_zero), .cmd(cmd), .row_idx(row_idx),
		.first_row(first_row), .err_out(pivot_error), .final_flag(final_out)
	);

	tds_datapath #(.MaxRows(MAX_ROWS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .row_idx(row_idx),
		.first_row(first_row), .sub_coef(sub_coef), .diag_coef(diag_coef),
		.super_coef(super_coef), .rhs_value(rhs_value), .stat(stat),
		.den_zero(den_zero), .x_value(solution_value)
	);

	assign solution_index = row_idx;

endmodule

// File: hdl/tds_divider.sv
// Iterative restoring divider: saturated Q16.16 quotient, one bit a cycle.
module tds_divider
	import tds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WordW-1:0] num,
	input  logic signed [WordW-1:0] den,
	output logic                    done,
	output logic signed [WordW-1:0] quo
);

	logic                busy_q;
	logic [5:0]          cnt_q;
	logic [QuoW-1:0]     dvd_q;
	logic [WordW:0]      rem_q;
	logic [WordW-1:0]    dsr_q;
	logic                neg_q;
	logic                zero_q;
	logic [WordW-1:0]    num_abs;
	logic [WordW-1:0]    den_abs;
	logic [WordW:0]      trial;
	logic [WordW:0]      rem_sh;
	logic signed [QuoW:0] sq;

	assign num_abs = num[WordW-1] ? WordW'(-num) : num;
	assign den_abs = den[WordW-1] ? WordW'(-den) : den;
	assign rem_sh  = {rem_q[WordW-1:0], dvd_q[QuoW-1]};
	assign trial   = rem_sh - {1'b0, dsr_q};
	assign sq      = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

	// Shift and subtract one quotient bit each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (den != '0);
				done   <= (den == '0);
				cnt_q  <= 6'(QuoW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= {1'b0, num_abs, 16'd0};
			rem_q   <= '0;
			dsr_q   <= den_abs;
			neg_q   <= num[WordW-1] ^ den[WordW-1];
			zero_q  <= (den == '0);
			quo     <= (num == '0) ? '0 : (num[WordW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		end else if (busy_q) begin
			if (!trial[WordW]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[QuoW-2:0], 1'b0};
			end
		end else if (!zero_q) begin
			if (sq > $signed(50'sh0_7FFF_FFFF)) begin
				quo <= 32'sh7FFF_FFFF;
			end else if (sq < -$signed(50'sh0_8000_0000)) begin
				quo <= 32'sh8000_0000;
			end else begin
				quo <= sq[WordW-1:0];
			end
		end
	end

endmodule

// File: hdl/tds_datapath.sv
// Datapath: row registers, stores, multiplier, divider and result register.
module tds_datapath
	import tds_pkg::*;
#(
	parameter int MaxRows = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tds_cmd_t                cmd,
	input  logic [IdxW-1:0]         row_idx,
	input  logic                    first_row,
	input  logic signed [WordW-1:0] sub_coef,
	input  logic signed [WordW-1:0] diag_coef,
	input  logic signed [WordW-1:0] super_coef,
	input  logic signed [WordW-1:0] rhs_value,
	output tds_stat_t               stat,
	output logic                    den_zero,
	output logic signed [WordW-1:0] x_value
);

	logic signed [WordW-1:0] cp_mem [MaxRows];
	logic signed [WordW-1:0] dp_mem [MaxRows];
	logic signed [WordW-1:0] a_q, b_q, c_q, d_q, den_q, num_q;
	logic signed [WordW-1:0] cp_rd_q, dp_rd_q;
	logic signed [63:0]      pc_q, pd_q;
	logic signed [WordW-1:0] quo;
	logic                    div_start;
	logic signed [WordW-1:0] div_num;

	assign div_start = cmd.start_div_c | cmd.start_div_d;
	assign div_num   = cmd.start_div_c ? c_q : num_q;

	tds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(den_q), .done(stat.div_done), .quo(quo)
	);

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.write_c) cp_mem[row_idx] <= quo;
		if (cmd.write_d) dp_mem[row_idx] <= quo;
		cp_rd_q <= cp_mem[row_idx];
		dp_rd_q <= dp_mem[row_idx];
	end

	// Row capture, products and differences; products floor on the shift.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q <= sub_coef;
			b_q <= diag_coef;
			c_q <= super_coef;
			d_q <= rhs_value;
		end
		if (cmd.bs_mul) begin
			pc_q <= a_q * cp_rd_q;
			pd_q <= a_q * dp_rd_q;
		end
		if (cmd.bs_read) begin
			pc_q <= cp_rd_q * x_value;
		end
		if (cmd.form_den) begin
			if (first_row) begin
				den_q <= b_q;
				num_q <= d_q;
			end else begin
				den_q <= sat48(48'(b_q) - 48'(pc_q >>> 16));
				num_q <= sat48(48'(d_q) - 48'(pd_q >>> 16));
			end
		end
		if (cmd.bs_form) begin
			if (cmd.bs_first) x_value <= dp_rd_q;
			else x_value <= sat48(48'(dp_rd_q) - 48'(pc_q >>> 16));
		end
	end

	assign den_zero = (den_q == '0);

endmodule

// File: hdl/tds_ctrl.sv
// Controller: sequences the forward sweep and the back substitution.
module tds_ctrl
	import tds_pkg::*;
#(
	parameter int MaxRows = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            last_row,
	input  logic            out_ready,
	output logic            out_valid,
	input  tds_stat_t       stat,
	input  logic            den_zero,
	output tds_cmd_t        cmd,
	output logic [IdxW-1:0] row_idx,
	output logic            first_row,
	output logic            err_out,
	output logic            final_flag
);

	tds_state_t      state_q, state_d;
	logic [IdxW:0]   count_q, count_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic            last_q, last_d;
	logic            err_q, err_d;
	logic            first_q, first_d;

	assign row_idx    = idx_q;
	assign first_row  = (count_q == '0);
	assign err_out    = err_q;
	assign final_flag = (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			err_q   <= 1'b0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
			err_q   <= err_d;
			first_q <= first_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		last_d    = last_q;
		err_d     = err_q;
		first_d   = first_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.bs_first = first_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = count_q[IdxW-1:0] - IdxW'(1);
				if (in_valid) begin
					cmd.capture = 1'b1;
					last_d      = last_row;
					if (count_q == (IdxW+1)'(MaxRows)) begin
						err_d = 1'b1;
						if (last_row) begin
							idx_d   = IdxW'(MaxRows - 1);
							first_d = 1'b1;
							state_d = ST_BS_RD;
						end
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				cmd.bs_mul = 1'b1;
				state_d    = ST_DEN;
			end
			ST_DEN: begin
				cmd.form_den = 1'b1;
				idx_d        = count_q[IdxW-1:0];
				state_d      = ST_DIV_C;
			end
			ST_DIV_C: begin
				if (den_zero) err_d = 1'b1;
				if (last_q) begin
					state_d = ST_DIV_D;
				end else begin
					cmd.start_div_c = 1'b1;
					state_d = ST_WAIT_C;
				end
			end
			ST_WAIT_C: begin
				if (stat.div_done) state_d = ST_DIV_D;
			end
			ST_DIV_D: begin
				cmd.write_c     = !last_q;
				cmd.start_div_d = 1'b1;
				state_d         = ST_WAIT_D;
			end
			ST_WAIT_D: begin
				if (stat.div_done) state_d = ST_WRITE_D;
			end
			// The quotient has settled; store it and close the row.
			ST_WRITE_D: begin
				cmd.write_d = 1'b1;
				count_d     = count_q + (IdxW+1)'(1);
				if (last_q) begin
					first_d = 1'b1;
					state_d = ST_BS_RD;
				end else begin
					idx_d   = count_q[IdxW-1:0];
					state_d = ST_IDLE;
				end
			end
			ST_BS_RD: begin
				if (count_q != '0 && state_q == ST_BS_RD && idx_q == count_q[IdxW-1:0]) begin
					idx_d = idx_q;
				end
				state_d = ST_BS_MUL;
			end
			ST_BS_MUL: begin
				cmd.bs_read = 1'b1;
				state_d     = ST_BS_OUT;
			end
			ST_BS_OUT: begin
				cmd.bs_form = 1'b1;
				state_d     = ST_BS_WAIT;
			end
			ST_BS_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					first_d = 1'b0;
					if (idx_q == '0) begin
						count_d = '0;
						err_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q - IdxW'(1);
						state_d = ST_BS_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/tds_checker.sv
// Port checker for the tridiagonal system solver, bound to the top level.
module tds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] solution_value,
	input logic [5:0]  solution_index,
	input logic        final_out
);

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(solution_value))
		else $error("output word changed while stalled");

	// No row is taken while results are offered.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during output");

	// The final flag marks index zero.
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_out == (solution_index == 6'd0)))
		else $error("final flag wrong");

endmodule

bind tridiagonal_system_solver tds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.solution_value(solution_value), .solution_index(solution_index),
	.final_out(final_out)
);

// File: tb/testbench.sv
// Self-checking testbench for the tridiagonal system solver, with a built-in Thomas predictor.
`timescale 1ns / 100ps

module testbench;
	import tds_pkg::*;

	localparam int MaxRows = 64;
	localparam int RowsWanted = 260;
	localparam longint CycleLimit = 2000000;
	localparam longint SatHi = 64'sd2147483647;
	localparam longint SatLo = -64'sd2147483648;

	typedef struct {
		logic signed [WordW-1:0] value;
		logic [IdxW-1:0]         index;
		logic                    fin;
		logic                    err;
	} solution_t;

	typedef struct {
		logic signed [WordW-1:0] a;
		logic signed [WordW-1:0] b;
		logic signed [WordW-1:0] c;
		logic signed [WordW-1:0] d;
		bit                      last;
		bit                      typed;
		logic signed [WordW-1:0] want;
		bit                      want_err;
	} row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [WordW-1:0] sub_coef;
	logic signed [WordW-1:0] diag_coef;
	logic signed [WordW-1:0] super_coef;
	logic signed [WordW-1:0] rhs_value;
	logic                    last_row;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [WordW-1:0] solution_value;
	logic [IdxW-1:0]         solution_index;
	logic                    final_out;
	logic                    pivot_error;

	// Predictor state: modified super-diagonal and right-hand side of the open system.
	longint    cp_store [MaxRows];
	longint    dp_store [MaxRows];
	int        rows_open;
	bit        pivot_bad;
	solution_t solutions_due [$];
	int        mismatches;
	int        words_seen;
	longint    cycles;
	bit        stall_done;

	tridiagonal_system_solver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sub_coef      (sub_coef),
		.diag_coef     (diag_coef),
		.super_coef    (super_coef),
		.rhs_value     (rhs_value),
		.last_row      (last_row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.solution_value(solution_value),
		.solution_index(solution_index),
		.final_out     (final_out),
		.pivot_error   (pivot_error)
	);

	// Clock and cycle watchdog.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clamp32(input longint v);
		if (v > SatHi) begin
			return SatHi;
		end
		if (v < SatLo) begin
			return SatLo;
		end
		return v;
	endfunction

	// Q16.16 product; the arithmetic shift rounds toward minus infinity.
	function automatic longint qmul(input longint x, input longint y);
		longint p;
		p = x * y;
		return p >>> 16;
	endfunction

	// Q16.16 quotient with saturation; a zero divisor flags the system.
	function automatic longint qdiv(input longint num, input longint den);
		if (den == 0) begin
			pivot_bad = 1'b1;
			if (num > 0) begin
				return SatHi;
			end
			if (num < 0) begin
				return SatLo;
			end
			return 0;
		end
		return clamp32((num * 65536) / den);
	endfunction

	// Forward sweep on one row; a last row also runs back substitution.
	task automatic solve_row(input logic signed [WordW-1:0] a, input logic signed [WordW-1:0] b,
			input logic signed [WordW-1:0] c, input logic signed [WordW-1:0] d, input bit last);
		longint    den;
		longint    num;
		longint    x;
		int        idx;
		solution_t s;
		if (rows_open >= MaxRows) begin
			pivot_bad = 1'b1;
		end else begin
			if (rows_open == 0) begin
				den = b;
				num = d;
			end else begin
				den = clamp32(longint'(b) - qmul(a, cp_store[rows_open-1]));
				num = clamp32(longint'(d) - qmul(a, dp_store[rows_open-1]));
			end
			if (den == 0) begin
				pivot_bad = 1'b1;
			end
			if (!last) begin
				cp_store[rows_open] = qdiv(c, den);
			end
			dp_store[rows_open] = qdiv(num, den);
			rows_open++;
		end
		if (last) begin
			x = 0;
			for (idx = rows_open - 1; idx >= 0; idx--) begin
				if (idx == rows_open - 1) begin
					x = dp_store[idx];
				end else begin
					x = clamp32(dp_store[idx] - qmul(cp_store[idx], x));
				end
				s.value = x[WordW-1:0];
				s.index = idx[IdxW-1:0];
				s.fin = (idx == 0);
				s.err = pivot_bad;
				solutions_due.push_back(s);
			end
			rows_open = 0;
			pivot_bad = 1'b0;
		end
	endtask

	// Offer one row after a gap and hold it until the solver takes it.
	task automatic send_row(input row_t r, input int gap);
		int        depth;
		solution_t s;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		sub_coef = r.a;
		diag_coef = r.b;
		super_coef = r.c;
		rhs_value = r.d;
		last_row = r.last;
		do @(posedge clk); while (!in_ready);
		depth = solutions_due.size();
		solve_row(r.a, r.b, r.c, r.d, r.last);
		if (r.typed) begin
			while (solutions_due.size() > depth) begin
				void'(solutions_due.pop_back());
			end
			s.value = r.want;
			s.index = '0;
			s.fin = 1'b1;
			s.err = r.want_err;
			solutions_due.push_back(s);
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic signed [WordW-1:0] small_signed(input int unsigned mag);
		logic signed [WordW-1:0] v;
		v = $urandom_range(0, mag);
		return ($urandom_range(0, 1) == 1) ? -v : v;
	endfunction

	// Random row; tame rows keep the off-diagonal terms below one in magnitude.
	function automatic row_t random_row(input bit tame, input bit last);
		row_t r;
		r.typed = 1'b0;
		r.last = last;
		if (tame) begin
			r.a = small_signed(32'hFFFF);
			r.c = small_signed(32'hFFFF);
			r.b = small_signed(32'h60000) + (($urandom_range(0, 1) == 1) ? 32'sh20000 : -32'sh20000);
			r.d = small_signed(32'hFFFFFF);
		end else begin
			r.a = $urandom;
			r.b = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
			r.c = $urandom;
			r.d = $urandom;
		end
		return r;
	endfunction

	// Directed rows; single-row systems carry a hand-worked answer.
	row_t directed [] = '{
		'{32'sh0, 32'sh10000, 32'sh0, 32'sh50000, 1, 1, 32'sh50000, 0},
		'{32'sh7FFFFFFF, 32'sh10000, 32'sh1234, 32'sh80000000, 1, 1, 32'sh80000000, 0},
		'{32'sh0, 32'sh0, 32'sh0, 32'sh10000, 1, 1, 32'sh7FFFFFFF, 1},
		'{32'sh0, 32'sh0, 32'sh0, -32'sh1, 1, 1, 32'sh80000000, 1},
		'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1, 1, 32'sh0, 1},
		'{32'sh0, 32'sh20000, 32'sh0, 32'sh7FFFFFFF, 1, 1, 32'sh3FFFFFFF, 0},
		'{32'sh0, 32'sh8000, 32'sh0, 32'sh7FFFFFFF, 1, 1, 32'sh7FFFFFFF, 0},
		'{32'sh0, 32'sh1, 32'sh0, 32'sh80000000, 1, 1, 32'sh80000000, 0},
		'{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0},
		'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0},
		'{-32'sh1, -32'sh1, -32'sh1, -32'sh1, 1, 0, 0, 0},
		'{32'sh0, 32'sh20000, -32'sh10000, 32'sh10000, 0, 0, 0, 0},
		'{-32'sh10000, 32'sh20000, -32'sh10000, 32'sh0, 0, 0, 0, 0},
		'{-32'sh10000, 32'sh20000, -32'sh10000, 32'sh0, 0, 0, 0, 0},
		'{-32'sh10000, 32'sh20000, 32'sh5555, 32'sh10000, 1, 0, 0, 0},
		'{32'sh0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 0},
		'{32'sh10000, 32'sh10000, 32'sh0, 32'sh30000, 0, 0, 0, 0},
		'{32'sh10000, 32'sh10000, 32'sh0, -32'sh20000, 1, 0, 0, 0}
	};

	// Stimulus: reset, directed rows, then random systems.
	initial begin
		int   sent;
		int   systems;
		int   len;
		int   k;
		bit   tame;
		row_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		sub_coef = '0;
		diag_coef = '0;
		super_coef = '0;
		rhs_value = '0;
		last_row = 1'b0;
		cycles = 0;
		rows_open = 0;
		pivot_bad = 1'b0;
		mismatches = 0;
		words_seen = 0;
		stall_done = 1'b0;
		foreach (cp_store[i]) begin
			cp_store[i] = 0;
			dp_store[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			send_row(directed[i], $urandom_range(0, 6));
		end

		sent = 0;
		systems = 0;
		while (sent < RowsWanted) begin
			if (systems == 6) begin
				len = MaxRows + 2;
			end else if ($urandom_range(0, 19) == 0) begin
				len = $urandom_range(7, 20);
			end else begin
				len = $urandom_range(1, 6);
			end
			tame = ($urandom_range(0, 3) != 0);
			for (k = 0; k < len; k++) begin
				r = random_row(tame, k == len - 1);
				send_row(r, ((sent / 20) % 3 == 2) ? 0 : $urandom_range(0, 6));
				sent++;
			end
			systems++;
			// Let the solver drain completely once before carrying on.
			if (systems == 12) begin
				wait (solutions_due.size() == 0);
				repeat (20) @(posedge clk);
			end
		end

		wait (solutions_due.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && solutions_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Receiver: random stalls per word, quiet stretches, one long hold-off.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (!stall_done && words_seen >= 30) begin
				stall_done = 1'b1;
				wait_cycles = 3000;
			end else if ((words_seen / 25) % 3 == 1) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 6);
			end
			repeat (wait_cycles) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check every accepted word against the oldest expectation.
	always @(posedge clk) begin
		solution_t s;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (solutions_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected word: value %h index %0d", solution_value,
						solution_index);
				end
			end else begin
				s = solutions_due.pop_front();
				if (s.value !== solution_value || s.index !== solution_index ||
						s.fin !== final_out || s.err !== pivot_error) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
							s.value, s.index, s.fin, s.err, solution_value,
							solution_index, final_out, pivot_error);
					end
				end
			end
		end
	end

endmodule

// File: files.f
hdl/tds_pkg.sv
hdl/tds_divider.sv
hdl/tds_datapath.sv
hdl/tds_ctrl.sv
hdl/tridiagonal_system_solver.sv
hdl/tds_checker.sv
tb/testbench.sv
